### rtl/quaternion_to_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// quaternion to rotation matrix assertion macros
// concurrent checks clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// same-cycle implication
`define QTRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qtrm_pkg.sv
// ----------------------------------------------------------------------------
// qtrm_pkg
// types and constants shared by the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
`default_nettype none

package qtrm_pkg;

  localparam int InWidth    = 16;
  localparam int FracBits   = 14;
  localparam int OutWidth   = FracBits + 2;
  localparam int ProdWidth  = 2 * InWidth;
  localparam int NormWidth  = ProdWidth + 2;
  localparam int NumWidth   = NormWidth + 2;
  localparam int QuotWidth  = FracBits + 2;
  localparam int NumEntries = 9;
  localparam int MidDepth   = 4;
  localparam int MidCntW    = $clog2(MidDepth + 1);
  localparam int OutDepth   = 2;
  localparam int OutCntW    = $clog2(OutDepth + 1);

  localparam logic [QuotWidth-1:0] OneFx = QuotWidth'(1) << FracBits;

  // entry order inside the work item
  localparam int EntR0C0 = 0;
  localparam int EntR1C0 = 1;
  localparam int EntR2C0 = 2;
  localparam int EntR0C1 = 3;
  localparam int EntR1C1 = 4;
  localparam int EntR2C1 = 5;
  localparam int EntR0C2 = 6;
  localparam int EntR1C2 = 7;
  localparam int EntR2C2 = 8;

  typedef struct packed {
    logic signed [InWidth-1:0] quat_w;
    logic signed [InWidth-1:0] quat_x;
    logic signed [InWidth-1:0] quat_y;
    logic signed [InWidth-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] r0c0;
    logic signed [OutWidth-1:0] r1c0;
    logic signed [OutWidth-1:0] r2c0;
    logic signed [OutWidth-1:0] r0c1;
    logic signed [OutWidth-1:0] r1c1;
    logic signed [OutWidth-1:0] r2c1;
    logic signed [OutWidth-1:0] r0c2;
    logic signed [OutWidth-1:0] r1c2;
    logic signed [OutWidth-1:0] r2c2;
    logic                       zero_norm;
  } rot_t;

  // classified item: norm, nine numerators, zero flag
  typedef struct packed {
    logic                                 zero_norm;
    logic [NormWidth-1:0]                 norm;
    logic [NumEntries-1:0][NumWidth-1:0]  num;
  } work_t;

  typedef struct packed {
    logic v1;
    logic v2;
  } front_stat_t;

  typedef struct packed {
    logic                 neg;
    logic [QuotWidth-1:0] quot;
    logic [NormWidth-1:0] rem;
  } lane_t;

endpackage

`default_nettype wire

### rtl/quaternion_to_rotation_matrix.sv
// path: front product and numerator registers, middle queue, 15 divider stages,
//   output queue; the divider stalls while the output queue is full
// throughput: one item per cycle while the output queue has room, set by the
//   fifteen-stage divider pipeline and the ten registered multipliers
// reset: asynchronous active low, clears all valid flags and queue counts;
//   data registers keep whatever they hold
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// quaternion in, 3x3 rotation matrix out as signed Q2.14 entries
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_rotation_matrix
  import qtrm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  output      logic  full,
  input  wire quat_t quat_i,
  output      logic  empty,
  input  wire logic  pop,
  output      rot_t  result_o
);

  `include "quaternion_to_rotation_matrix_assert.svh"

  // front: products and numerators, feeds the middle queue
  logic        front_valid;
  work_t       front_work;
  front_stat_t front_stat;
  logic        accept;

  assign accept = push && !full;

  qtrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .quat_i  (quat_i),
    .valid_o (front_valid),
    .work_o  (front_work),
    .stat_o  (front_stat)
  );

  // middle queue decouples front from divider
  logic               mid_empty;
  work_t              mid_work;
  logic [MidCntW-1:0] mid_count;
  logic               mid_pop;
  logic [MidCntW-1:0] credit;

  qtrm_queue #(
    .DATA_T (work_t),
    .DEPTH  (MidDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_work),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_work),
    .count_o (mid_count)
  );

  // items in the front still count against the queue space
  assign credit = mid_count + MidCntW'(front_stat.v1) + MidCntW'(front_stat.v2);
  assign full   = (credit >= MidCntW'(MidDepth));

  // back: divider pipeline, moves whenever the output queue has room
  logic               back_adv;
  logic               back_valid;
  rot_t               back_result;
  logic [OutCntW-1:0] out_count;

  assign back_adv = (out_count < OutCntW'(OutDepth));
  assign mid_pop  = back_adv && !mid_empty;

  qtrm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (back_adv),
    .valid_i  (mid_pop),
    .work_i   (mid_work),
    .valid_o  (back_valid),
    .result_o (back_result)
  );

  // output queue holds finished items for the consumer
  qtrm_queue #(
    .DATA_T (rot_t),
    .DEPTH  (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_adv && back_valid),
    .data_i  (back_result),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (result_o),
    .count_o (out_count)
  );

  // an all-zero quaternion must come out as identity
  `QTRM_ASSERT_NOW(a_zero_identity, !empty && result_o.zero_norm,
    result_o.r0c0 == OutWidth'(OneFx) && result_o.r1c1 == OutWidth'(OneFx) &&
    result_o.r2c2 == OutWidth'(OneFx) && result_o.r1c0 == '0,
    "zero norm item is not identity")

  // entries never leave +/-1.0
  `QTRM_ASSERT_NOW(a_entry_range, !empty,
    result_o.r0c0 <= $signed(OutWidth'(OneFx)) && result_o.r0c0 >= -$signed(OutWidth'(OneFx)) &&
    result_o.r1c2 <= $signed(OutWidth'(OneFx)) && result_o.r1c2 >= -$signed(OutWidth'(OneFx)),
    "matrix entry out of range")

  // credit scheme keeps the middle queue from overflowing
  `QTRM_ASSERT_NEXT(a_mid_credit, accept,
    credit <= MidCntW'(MidDepth), "middle queue credit exceeded")

endmodule

`default_nettype wire

### rtl/qtrm_queue.sv
// ----------------------------------------------------------------------------
// qtrm_queue
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`default_nettype none

module qtrm_queue #(
  parameter type         DATA_T = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire DATA_T                          data_i,
  input  wire logic                           pop_i,
  output      logic                           empty_o,
  output      DATA_T                          data_o,
  output      logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  DATA_T            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

### rtl/qtrm_front.sv
// ----------------------------------------------------------------------------
// qtrm_front
// products of the quaternion terms, then norm and nine numerators
// ----------------------------------------------------------------------------
`default_nettype none

module qtrm_front
  import qtrm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire quat_t       quat_i,
  output      logic        valid_o,
  output      work_t       work_o,
  output      front_stat_t stat_o
);

  logic                        v1_q, v2_q;
  logic signed [ProdWidth-1:0] ww_q, xx_q, yy_q, zz_q;
  logic signed [ProdWidth-1:0] xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  work_t                       work_d, work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: ten products
  always_ff @(posedge clk_i) begin
    ww_q <= quat_i.quat_w * quat_i.quat_w;
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    wx_q <= quat_i.quat_w * quat_i.quat_x;
    wy_q <= quat_i.quat_w * quat_i.quat_y;
    wz_q <= quat_i.quat_w * quat_i.quat_z;
  end

  // stage 2: norm and numerators
  always_comb begin
    logic signed [NumWidth-1:0] sww, sxx, syy, szz, sxy, sxz, syz, swx, swy, swz, sn;
    sww = NumWidth'(ww_q);
    sxx = NumWidth'(xx_q);
    syy = NumWidth'(yy_q);
    szz = NumWidth'(zz_q);
    sxy = NumWidth'(xy_q);
    sxz = NumWidth'(xz_q);
    syz = NumWidth'(yz_q);
    swx = NumWidth'(wx_q);
    swy = NumWidth'(wy_q);
    swz = NumWidth'(wz_q);
    sn  = sww + sxx + syy + szz;
    work_d.norm          = sn[NormWidth-1:0];
    work_d.zero_norm     = (sn == '0);
    work_d.num[EntR0C0]  = sn - ((syy + szz) <<< 1);
    work_d.num[EntR1C0]  = (sxy + swz) <<< 1;
    work_d.num[EntR2C0]  = (sxz - swy) <<< 1;
    work_d.num[EntR0C1]  = (sxy - swz) <<< 1;
    work_d.num[EntR1C1]  = sn - ((sxx + szz) <<< 1);
    work_d.num[EntR2C1]  = (syz + swx) <<< 1;
    work_d.num[EntR0C2]  = (sxz + swy) <<< 1;
    work_d.num[EntR1C2]  = (syz - swx) <<< 1;
    work_d.num[EntR2C2]  = sn - ((sxx + syy) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o   = v2_q;
  assign work_o    = work_q;
  assign stat_o.v1 = v1_q;
  assign stat_o.v2 = v2_q;

endmodule

`default_nettype wire

### rtl/qtrm_back.sv
// ----------------------------------------------------------------------------
// qtrm_back
// nine pipelined restoring dividers, one quotient bit per stage, with rounding
// ----------------------------------------------------------------------------
`default_nettype none

module qtrm_back
  import qtrm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire logic  valid_i,
  input  wire work_t work_i,
  output      logic  valid_o,
  output      rot_t  result_o
);

  localparam int Stages = FracBits + 1;

  logic                           v_q    [Stages];
  logic                           zero_q [Stages];
  logic [NormWidth-1:0]           norm_q [Stages];
  lane_t [NumEntries-1:0]         lane_q [Stages];
  lane_t [NumEntries-1:0]         lane0_d;

  function automatic lane_t div_step(lane_t l, logic [NormWidth-1:0] n);
    lane_t               o;
    logic [NormWidth:0]  two_r;
    o     = l;
    two_r = {l.rem, 1'b0};
    if (two_r >= {1'b0, n}) begin
      o.rem  = NormWidth'(two_r - {1'b0, n});
      o.quot = {l.quot[QuotWidth-2:0], 1'b1};
    end else begin
      o.rem  = two_r[NormWidth-1:0];
      o.quot = {l.quot[QuotWidth-2:0], 1'b0};
    end
    return o;
  endfunction

  // first stage: sign, magnitude clamp, integer quotient bit
  always_comb begin
    logic [NumWidth-1:0] mag;
    for (int e = 0; e < NumEntries; e++) begin
      lane0_d[e].neg = work_i.num[e][NumWidth-1];
      mag = lane0_d[e].neg ? (~work_i.num[e] + NumWidth'(1)) : work_i.num[e];
      if (mag >= {2'b00, work_i.norm}) begin
        lane0_d[e].quot = QuotWidth'(1);
        lane0_d[e].rem  = '0;
      end else begin
        lane0_d[e].quot = '0;
        lane0_d[e].rem  = mag[NormWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < Stages; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zero_q[0] <= work_i.zero_norm;
      norm_q[0] <= work_i.norm;
      lane_q[0] <= lane0_d;
      for (int s = 1; s < Stages; s++) begin
        zero_q[s] <= zero_q[s-1];
        norm_q[s] <= norm_q[s-1];
        for (int e = 0; e < NumEntries; e++) begin
          lane_q[s][e] <= div_step(lane_q[s-1][e], norm_q[s-1]);
        end
      end
    end
  end

  // last stage: round half away, clamp, restore sign
  logic [NumEntries-1:0][OutWidth-1:0] ent;

  always_comb begin
    logic [QuotWidth-1:0] q;
    logic [NormWidth:0]   two_r;
    for (int e = 0; e < NumEntries; e++) begin
      two_r = {lane_q[Stages-1][e].rem, 1'b0};
      q     = lane_q[Stages-1][e].quot;
      if (two_r >= {1'b0, norm_q[Stages-1]}) begin
        q = q + QuotWidth'(1);
      end
      if (q > OneFx) begin
        q = OneFx;
      end
      ent[e] = lane_q[Stages-1][e].neg ? OutWidth'(~q + QuotWidth'(1)) : OutWidth'(q);
    end
  end

  always_comb begin
    if (zero_q[Stages-1]) begin
      result_o.r0c0 = OutWidth'(OneFx);
      result_o.r1c0 = '0;
      result_o.r2c0 = '0;
      result_o.r0c1 = '0;
      result_o.r1c1 = OutWidth'(OneFx);
      result_o.r2c1 = '0;
      result_o.r0c2 = '0;
      result_o.r1c2 = '0;
      result_o.r2c2 = OutWidth'(OneFx);
    end else begin
      result_o.r0c0 = ent[EntR0C0];
      result_o.r1c0 = ent[EntR1C0];
      result_o.r2c0 = ent[EntR2C0];
      result_o.r0c1 = ent[EntR0C1];
      result_o.r1c1 = ent[EntR1C1];
      result_o.r2c1 = ent[EntR2C1];
      result_o.r0c2 = ent[EntR0C2];
      result_o.r1c2 = ent[EntR1C2];
      result_o.r2c2 = ent[EntR2C2];
    end
    result_o.zero_norm = zero_q[Stages-1];
  end

  assign valid_o = v_q[Stages-1];

endmodule

`default_nettype wire
